/* rtl/ptfl_pkg.sv */
// package for the page translator: sizes, status codes and shared types
// no dependencies
`default_nettype none
package ptfl_pkg;
    localparam int VPAGES      = 256;
    localparam int FRAMES      = 16;
    localparam int VP_W        = 8;
    localparam int FR_W        = 4;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int VADDR_W     = 24;
    localparam int PADDR_W     = 20;
    localparam int PB_W        = 17;
    localparam int NVP_W       = 9;
    localparam int NFR_W       = 5;
    localparam int ST_W        = 3;
    localparam int PADDR_BITS  = 5;

    localparam logic [ST_W-1:0] ST_HIT     = 3'd0;
    localparam logic [ST_W-1:0] ST_FREE    = 3'd1;
    localparam logic [ST_W-1:0] ST_REPLACE = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOINIT  = 3'd4;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd5;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_PAGE   = 3'd1;
    localparam logic [2:0] REG_VPAGES = 3'd2;
    localparam logic [2:0] REG_FRAMES = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;

    typedef struct packed {
        logic start_div;
        logic do_clear;
        logic start_scan;
        logic scan_step;
        logic commit;
        logic mul_step;
        logic [ST_W-1:0] result_status;
        logic load_out;
    } ptfl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic in_range;
        logic hit;
        logic scan_done;
        logic mul_done;
        logic noinit;
        logic victim_used;
    } ptfl_sts_t;
endpackage
`default_nettype wire

/* rtl/ptfl_if.sv */
// valid/ready channel interfaces for items in and results out
// uses ptfl_pkg
`default_nettype none
interface ptfl_in_if;
    import ptfl_pkg::*;
    logic valid;
    logic ready;
    logic func;
    logic [VADDR_W-1:0] vaddr;
    modport source (output valid, output func, output vaddr, input ready);
    modport sink (input valid, input func, input vaddr, output ready);
endinterface

interface ptfl_out_if;
    import ptfl_pkg::*;
    logic valid;
    logic ready;
    logic [ST_W-1:0] status;
    logic [VP_W-1:0] vpage;
    logic [FR_W-1:0] frame;
    logic [PADDR_W-1:0] paddr;
    logic [CNT_W-1:0] access_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] fault_count;
    modport source (output valid, output status, output vpage, output frame, output paddr,
        output access_count, output hit_count, output fault_count, input ready);
    modport sink (input valid, input status, input vpage, input frame, input paddr,
        input access_count, input hit_count, input fault_count, output ready);
endinterface
`default_nettype wire

/* rtl/ptfl_ram.sv */
// generic simple dual port ram (separate write and read address) with registered read
// no dependencies
`default_nettype none
module ptfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/ptfl_datapath.sv */
// datapath: divider, page table, frame table scan, multiplier, counters
// uses ptfl_pkg and ptfl_ram
`default_nettype none
module ptfl_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ptfl_pkg::ptfl_cmd_t         cmd,
    output ptfl_pkg::ptfl_sts_t              sts,
    input  wire logic                        in_func,
    input  wire logic [ptfl_pkg::VADDR_W-1:0] in_vaddr,
    input  wire logic                        cfg_enable,
    input  wire logic [ptfl_pkg::PB_W-1:0]   cfg_page,
    input  wire logic [ptfl_pkg::NVP_W-1:0]  cfg_vpages,
    input  wire logic [ptfl_pkg::NFR_W-1:0]  cfg_frames,
    input  wire logic                        cfg_mode,
    output logic      [ptfl_pkg::ST_W-1:0]   o_status,
    output logic      [ptfl_pkg::VP_W-1:0]   o_vpage,
    output logic      [ptfl_pkg::FR_W-1:0]   o_frame,
    output logic      [ptfl_pkg::PADDR_W-1:0] o_paddr,
    output logic      [ptfl_pkg::CNT_W-1:0]  o_acc,
    output logic      [ptfl_pkg::CNT_W-1:0]  o_hit,
    output logic      [ptfl_pkg::CNT_W-1:0]  o_flt
);
    import ptfl_pkg::*;

    localparam int DCNT_W = $clog2(VADDR_W + 1);
    localparam int MCNT_W = $clog2(FR_W + 1);
    localparam int MIDX_W = $clog2(FR_W);

    // divider: restoring, one quotient bit a cycle
    logic [VADDR_W-1:0] quo_reg, quo_next;
    logic [PB_W-1:0]    rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [VADDR_W-1:0] vaddr_reg;
    logic               func_reg;
    logic [PB_W:0]      trial;

    // scan
    logic [FR_W-1:0]    sidx_reg, sidx_next;
    logic [FR_W-1:0]    best_reg, best_next;
    logic [TIME_W-1:0]  bestt_reg, bestt_next;
    logic               found_free_reg, found_free_next;
    logic               sdone_reg, sdone_next;

    // shift-add multiply frame * page_bytes, added onto the page offset
    logic [PADDR_W-1:0] prod_reg, prod_next;
    logic [MCNT_W-1:0]  mcnt_reg, mcnt_next;
    logic [FR_W-1:0]    fr_reg, fr_next;
    logic [MIDX_W-1:0]  mbit;

    logic [VPAGES-1:0]  pvalid_reg;
    logic [FRAMES-1:0]  fused_reg;
    logic [VP_W-1:0]    fowner [FRAMES];
    logic [TIME_W-1:0]  fload [FRAMES];
    logic [TIME_W-1:0]  facc [FRAMES];
    logic [TIME_W-1:0]  clk_time_reg;
    logic [CNT_W-1:0]   acc_reg, hit_reg, flt_reg;
    logic [FR_W-1:0]    pt_rdata;
    logic               pt_we;
    logic [VP_W-1:0]    vp;
    logic [NFR_W-1:0]   nfr;
    logic [NVP_W-1:0]   nvp;
    logic [PB_W+NVP_W-1:0] limit;
    logic [TIME_W-1:0]  tsel;
    logic [TIME_W-1:0]  tnow;

    assign vp  = quo_reg[VP_W-1:0];
    assign nvp = (cfg_vpages > NVP_W'(VPAGES)) ? NVP_W'(VPAGES) : cfg_vpages;
    assign nfr = (cfg_frames > NFR_W'(FRAMES)) ? NFR_W'(FRAMES) : cfg_frames;
    assign limit = PB_W'(0) + {{NVP_W{1'b0}}, cfg_page} * {{PB_W{1'b0}}, nvp};
    assign tnow = (clk_time_reg == '1) ? clk_time_reg : clk_time_reg + 1'b1;

    assign sts.noinit = !cfg_enable || cfg_page == '0 || nvp == '0 || nfr == '0;
    assign sts.div_done = dcnt_reg == '0;
    assign sts.in_range = !func_reg
        && ({{(PB_W+NVP_W-VADDR_W){1'b0}}, vaddr_reg} < limit);
    assign sts.hit = pvalid_reg[vp];
    assign sts.scan_done = sdone_reg;
    assign sts.mul_done = mcnt_reg == '0;
    assign sts.victim_used = !found_free_reg;

    assign trial = {rem_reg, quo_reg[VADDR_W-1]} - {1'b0, cfg_page};
    assign tsel = cfg_mode ? facc[sidx_reg] : fload[sidx_reg];
    assign mbit = MIDX_W'(mcnt_reg - 1'b1);

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        if (cmd.start_div)
        begin
            quo_next = in_vaddr;
            rem_next = '0;
            dcnt_next = DCNT_W'(VADDR_W);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_next = dcnt_reg - 1'b1;
            if (!trial[PB_W])
            begin
                rem_next = trial[PB_W-1:0];
                quo_next = {quo_reg[VADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[PB_W-2:0], quo_reg[VADDR_W-1]};
                quo_next = {quo_reg[VADDR_W-2:0], 1'b0};
            end
        end
    end

    // scan: first free frame, else oldest time, ties to the lowest
    always_comb
    begin
        sidx_next = sidx_reg;
        best_next = best_reg;
        bestt_next = bestt_reg;
        found_free_next = found_free_reg;
        sdone_next = sdone_reg;
        if (cmd.start_scan)
        begin
            sidx_next = '0;
            best_next = '0;
            bestt_next = '1;
            found_free_next = 1'b0;
            sdone_next = 1'b0;
        end
        else if (cmd.scan_step && !sdone_reg)
        begin
            if (!fused_reg[sidx_reg])
            begin
                best_next = sidx_reg;
                found_free_next = 1'b1;
                sdone_next = 1'b1;
            end
            else
            begin
                if (sidx_reg == '0 || tsel < bestt_reg)
                begin
                    best_next = sidx_reg;
                    bestt_next = tsel;
                end
                if ({1'b0, sidx_reg} == nfr - 1'b1)
                begin
                    sdone_next = 1'b1;
                end
                sidx_next = sidx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        prod_next = prod_reg;
        mcnt_next = mcnt_reg;
        fr_next = fr_reg;
        if (cmd.commit)
        begin
            fr_next = sts.hit ? pt_rdata : best_reg;
            prod_next = PADDR_W'(rem_reg);
            mcnt_next = MCNT_W'(FR_W);
        end
        else if (cmd.mul_step && mcnt_reg != '0)
        begin
            mcnt_next = mcnt_reg - 1'b1;
            if (fr_reg[mbit])
            begin
                prod_next = prod_reg + PADDR_W'({cfg_page, {FR_W{1'b0}}} >> (FR_W + 1 - mcnt_reg));
            end
        end
    end

    assign pt_we = cmd.commit && !sts.hit;

    ptfl_ram #(.WIDTH(FR_W), .DEPTH(VPAGES)) u_page_frame (
        .clk   (clk),
        .we    (pt_we),
        .waddr (vp),
        .wdata (best_reg),
        .raddr (vp),
        .rdata (pt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            sdone_reg <= 1'b0;
            mcnt_reg <= '0;
            pvalid_reg <= '0;
            fused_reg <= '0;
            clk_time_reg <= '0;
            acc_reg <= '0;
            hit_reg <= '0;
            flt_reg <= '0;
        end
        else
        begin
            dcnt_reg <= dcnt_next;
            sdone_reg <= sdone_next;
            mcnt_reg <= mcnt_next;
            if (cmd.do_clear)
            begin
                pvalid_reg <= '0;
                fused_reg <= '0;
                clk_time_reg <= '0;
                acc_reg <= '0;
                hit_reg <= '0;
                flt_reg <= '0;
            end
            else if (cmd.commit)
            begin
                clk_time_reg <= tnow;
                if (acc_reg != '1) acc_reg <= acc_reg + 1'b1;
                if (sts.hit)
                begin
                    if (hit_reg != '1) hit_reg <= hit_reg + 1'b1;
                end
                else
                begin
                    if (flt_reg != '1) flt_reg <= flt_reg + 1'b1;
                    if (fused_reg[best_reg])
                    begin
                        pvalid_reg[fowner[best_reg]] <= 1'b0;
                    end
                    pvalid_reg[vp] <= 1'b1;
                    fused_reg[best_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        sidx_reg <= sidx_next;
        best_reg <= best_next;
        bestt_reg <= bestt_next;
        found_free_reg <= found_free_next;
        prod_reg <= prod_next;
        fr_reg <= fr_next;
        if (cmd.start_div)
        begin
            vaddr_reg <= in_vaddr;
            func_reg <= in_func;
        end
        if (cmd.commit)
        begin
            if (sts.hit)
            begin
                facc[pt_rdata] <= tnow;
            end
            else
            begin
                fowner[best_reg] <= vp;
                fload[best_reg] <= tnow;
                facc[best_reg] <= tnow;
            end
        end
        if (cmd.load_out)
        begin
            o_status <= cmd.result_status;
            if (cmd.result_status == ST_HIT || cmd.result_status == ST_FREE
                || cmd.result_status == ST_REPLACE)
            begin
                o_vpage <= vp;
                o_frame <= fr_reg;
                o_paddr <= prod_reg;
            end
            else
            begin
                o_vpage <= '0;
                o_frame <= '0;
                o_paddr <= '0;
            end
            o_acc <= cmd.do_clear ? '0 : acc_reg;
            o_hit <= cmd.do_clear ? '0 : hit_reg;
            o_flt <= cmd.do_clear ? '0 : flt_reg;
        end
    end
endmodule
`default_nettype wire

/* rtl/ptfl_ctrl.sv */
// controller state machine sequencing divide, lookup, scan, commit, multiply
// uses ptfl_pkg
`default_nettype none
module ptfl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_func,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ptfl_pkg::ptfl_cmd_t      cmd,
    input  wire ptfl_pkg::ptfl_sts_t sts
);
    import ptfl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_LOOK, S_SCAN, S_COMMIT, S_MUL, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   repl_reg;
    logic   hit_reg;
    logic   accept;

    assign in_ready = state_reg == S_IDLE && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.start_div = accept;
        cmd.start_scan = state_reg == S_LOOK;
        cmd.scan_step = state_reg == S_SCAN;
        cmd.commit = state_reg == S_COMMIT;
        cmd.mul_step = state_reg == S_MUL;
        if (accept && sts.noinit)
        begin
            cmd.load_out = 1'b1;
            cmd.result_status = ST_NOINIT;
        end
        else if (accept && in_func)
        begin
            cmd.load_out = 1'b1;
            cmd.do_clear = 1'b1;
            cmd.result_status = ST_CLEARED;
        end
        else if (state_reg == S_DIV && sts.div_done && !sts.in_range)
        begin
            cmd.load_out = 1'b1;
            cmd.result_status = ST_RANGE;
        end
        else if (state_reg == S_OUT)
        begin
            cmd.load_out = 1'b1;
            cmd.result_status = hit_reg ? ST_HIT : (repl_reg ? ST_REPLACE : ST_FREE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            repl_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && !sts.noinit && !in_func)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= sts.in_range ? S_LOOK : S_IDLE;
                    end
                end
                S_LOOK:
                begin
                    hit_reg <= sts.hit;
                    state_reg <= sts.hit ? S_COMMIT : S_SCAN;
                end
                S_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    repl_reg <= sts.victim_used;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (sts.mul_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/page_translate_fifo_lru.sv */
// A translation runs from accept to result through the bit-serial divide of the address
// by the page size, the page table read, the frame scan on a fault, the commit, the
// shift-add frame times page size plus offset and the loading of the result. An
// out-of-range address answers right after the divide. Clear and not-initialized items
// answer in the cycle after they are accepted. One item is in work at a time; the next
// is taken once the result is gone.
// top level: apb register file, controller and datapath
// uses ptfl_pkg, ptfl_if, ptfl_ctrl, ptfl_datapath
`default_nettype none
module page_translate_fifo_lru (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ptfl_in_if.sink                              in_ch,
    ptfl_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ptfl_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    import ptfl_pkg::*;

    logic               enable_reg;
    logic [PB_W-1:0]    page_reg;
    logic [NVP_W-1:0]   vpages_reg;
    logic [NFR_W-1:0]   frames_reg;
    logic               mode_reg;
    logic [2:0]         ridx;
    ptfl_cmd_t          cmd;
    ptfl_sts_t          sts;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            page_reg <= PB_W'(4096);
            vpages_reg <= NVP_W'(256);
            frames_reg <= NFR_W'(16);
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (ridx)
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_PAGE:   page_reg <= pwdata[PB_W-1:0];
                REG_VPAGES: vpages_reg <= pwdata[NVP_W-1:0];
                REG_FRAMES: frames_reg <= pwdata[NFR_W-1:0];
                REG_MODE:   mode_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_ENABLE: prdata = {31'b0, enable_reg};
            REG_PAGE:   prdata = {{(32-PB_W){1'b0}}, page_reg};
            REG_VPAGES: prdata = {{(32-NVP_W){1'b0}}, vpages_reg};
            REG_FRAMES: prdata = {{(32-NFR_W){1'b0}}, frames_reg};
            REG_MODE:   prdata = {31'b0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    ptfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ptfl_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_func    (in_ch.func),
        .in_vaddr   (in_ch.vaddr),
        .cfg_enable (enable_reg),
        .cfg_page   (page_reg),
        .cfg_vpages (vpages_reg),
        .cfg_frames (frames_reg),
        .cfg_mode   (mode_reg),
        .o_status   (out_ch.status),
        .o_vpage    (out_ch.vpage),
        .o_frame    (out_ch.frame),
        .o_paddr    (out_ch.paddr),
        .o_acc      (out_ch.access_count),
        .o_hit      (out_ch.hit_count),
        .o_flt      (out_ch.fault_count)
    );
endmodule
`default_nettype wire

/* tb/tb_page_translate_fifo_lru.sv */
// testbench for page_translate_fifo_lru: random and directed translations, checked
// against an in-bench model of the page table with fifo and lru replacement
// uses ptfl_pkg, ptfl_if and the rtl top level
`timescale 1ns / 100ps
`default_nettype none
module tb_page_translate_fifo_lru;
    import ptfl_pkg::*;

    typedef struct packed {
        logic               func;
        logic [VADDR_W-1:0] vaddr;
    } xlat_req_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VP_W-1:0]    vpage;
        logic [FR_W-1:0]    frame;
        logic [PADDR_W-1:0] paddr;
        logic [CNT_W-1:0]   acc;
        logic [CNT_W-1:0]   hit;
        logic [CNT_W-1:0]   flt;
    } xlat_rsp_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ptfl_in_if  in_ch();
    ptfl_out_if out_ch();

    page_translate_fifo_lru u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic             m_enable;
    logic [PB_W-1:0]  m_page_bytes;
    logic [NVP_W-1:0] m_vpages;
    logic [NFR_W-1:0] m_frames;
    logic             m_lru;
    logic             pg_valid [VPAGES];
    logic [FR_W-1:0]  pg_frame [VPAGES];
    logic             fr_used [FRAMES];
    logic [VP_W-1:0]  fr_owner [FRAMES];
    logic [TIME_W-1:0] fr_load [FRAMES];
    logic [TIME_W-1:0] fr_touch [FRAMES];
    logic [TIME_W-1:0] now_time;
    logic [CNT_W-1:0] n_acc, n_hit, n_flt;

    xlat_req_t pending_reqs[$];
    xlat_rsp_t expected_rsps[$];
    int  mismatches;
    int  phase;
    bit  hold_off;
    longint cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void wipe_tables();
        for (int i = 0; i < VPAGES; i++)
            pg_valid[i] = 1'b0;
        for (int i = 0; i < FRAMES; i++)
            fr_used[i] = 1'b0;
        now_time = '0;
        n_acc = '0;
        n_hit = '0;
        n_flt = '0;
    endfunction

    function automatic xlat_rsp_t translate(xlat_req_t rq);
        xlat_rsp_t r;
        longint nvp, nfr, vp, off, span;
        int f;
        logic [TIME_W-1:0] best_t, t;
        r = '0;
        nvp = (m_vpages > VPAGES) ? VPAGES : m_vpages;
        nfr = (m_frames > FRAMES) ? FRAMES : m_frames;
        span = nvp * longint'(m_page_bytes);
        if (!m_enable || m_page_bytes == 0 || nvp == 0 || nfr == 0)
            r.status = ST_NOINIT;
        else if (rq.func)
        begin
            wipe_tables();
            r.status = ST_CLEARED;
        end
        else if (longint'(rq.vaddr) >= span)
            r.status = ST_RANGE;
        else
        begin
            vp = longint'(rq.vaddr) / longint'(m_page_bytes);
            off = longint'(rq.vaddr) % longint'(m_page_bytes);
            if (now_time != '1)
                now_time = now_time + 1'b1;
            n_acc = sat_add(n_acc);
            if (pg_valid[vp])
            begin
                n_hit = sat_add(n_hit);
                f = pg_frame[vp];
                fr_touch[f] = now_time;
                r.status = ST_HIT;
            end
            else
            begin
                n_flt = sat_add(n_flt);
                f = -1;
                for (int i = 0; i < nfr; i++)
                    if (f < 0 && !fr_used[i])
                        f = i;
                if (f < 0)
                begin
                    f = 0;
                    best_t = m_lru ? fr_touch[0] : fr_load[0];
                    for (int i = 1; i < nfr; i++)
                    begin
                        t = m_lru ? fr_touch[i] : fr_load[i];
                        if (t < best_t)
                        begin
                            best_t = t;
                            f = i;
                        end
                    end
                end
                if (fr_used[f])
                begin
                    pg_valid[fr_owner[f]] = 1'b0;
                    r.status = ST_REPLACE;
                end
                else
                    r.status = ST_FREE;
                fr_used[f] = 1'b1;
                fr_owner[f] = vp[VP_W-1:0];
                pg_valid[vp] = 1'b1;
                pg_frame[vp] = f[FR_W-1:0];
                fr_load[f] = now_time;
                fr_touch[f] = now_time;
            end
            r.vpage = vp[VP_W-1:0];
            r.frame = f[FR_W-1:0];
            r.paddr = PADDR_W'(longint'(f) * longint'(m_page_bytes) + off);
        end
        r.acc = n_acc;
        r.hit = n_hit;
        r.flt = n_flt;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: m_enable = val[0];
            REG_PAGE:   m_page_bytes = val[PB_W-1:0];
            REG_VPAGES: m_vpages = val[NVP_W-1:0];
            REG_FRAMES: m_frames = val[NFR_W-1:0];
            REG_MODE:   m_lru = val[0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(int pb, int nvp, int nfr, bit lru);
        write_reg(REG_PAGE, pb);
        write_reg(REG_VPAGES, nvp);
        write_reg(REG_FRAMES, nfr);
        write_reg(REG_MODE, lru);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic xlat_req_t mk(bit fn, int a);
        xlat_req_t q;
        q.func = fn;
        q.vaddr = a[VADDR_W-1:0];
        return q;
    endfunction

    // mostly in-range addresses, clustered on few pages so hits and evictions both occur
    task automatic push_random(int n);
        longint span, pb, a;
        int vp;
        pb = (m_page_bytes == 0) ? 1 : m_page_bytes;
        span = ((m_vpages > VPAGES) ? VPAGES : m_vpages) * pb;
        if (span == 0)
            span = 1;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: pending_reqs.push_back(mk(1'b1, $urandom));
                1, 2: pending_reqs.push_back(mk(1'b0, $urandom));
                3: pending_reqs.push_back(mk(1'b0, int'(span - 1 + $urandom_range(0, 1))));
                default:
                begin
                    vp = $urandom_range(0, (span / pb > 24) ? 23 : int'(span / pb) - 1);
                    if ($urandom_range(0, 3) == 0)
                        a = longint'($urandom) % span;
                    else
                        a = longint'(vp) * pb + longint'($urandom) % pb;
                    pending_reqs.push_back(mk(1'b0, int'(a)));
                end
            endcase
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.func  <= 1'b0;
            in_ch.vaddr <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_rsps.push_back(translate(pending_reqs.pop_front()));
            end
            if ((in_ch.valid && !in_ch.ready) ||
                (pending_reqs.size() > 0 && !(in_ch.valid && in_ch.ready) && in_ch.valid))
                ;
            else if (pending_reqs.size() > 0 && !(in_ch.valid && in_ch.ready && pending_reqs.size() == 0)
                     && !((phase == 1 || phase == 3) && $urandom_range(0, 99) < 78))
            begin
                in_ch.valid <= 1'b1;
                in_ch.func  <= pending_reqs[0].func;
                in_ch.vaddr <= pending_reqs[0].vaddr;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        xlat_rsp_t got, want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = out_ch.status;
                got.vpage  = out_ch.vpage;
                got.frame  = out_ch.frame;
                got.paddr  = out_ch.paddr;
                got.acc    = out_ch.access_count;
                got.hit    = out_ch.hit_count;
                got.flt    = out_ch.fault_count;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            out_ch.ready <= !hold_off &&
                !((phase == 2 || phase == 3) && $urandom_range(0, 99) < 78);
        end
    end

    // long receiver hold-off so the block backs up
    initial
    begin
        int n;
        hold_off = 1'b0;
        wait (phase == 4);
        hold_off = 1'b1;
        n = 0;
        while (n < 400)
        begin
            @(posedge clk);
            n++;
        end
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("tb_page_translate_fifo_lru failed");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        mismatches = 0;
        phase = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        m_enable = 1'b0;
        m_page_bytes = 4096;
        m_vpages = 256;
        m_frames = 16;
        m_lru = 1'b0;
        wipe_tables();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not initialized, clear included
        pending_reqs.push_back(mk(1'b0, 0));
        pending_reqs.push_back(mk(1'b1, 0));
        drain();
        write_reg(REG_ENABLE, 1);
        set_sizes(0, 4, 4, 0);
        pending_reqs.push_back(mk(1'b0, 0));
        drain();
        set_sizes(100, 4, 2, 0);
        // fill, hit, fifo eviction, out of range, extremes
        pending_reqs.push_back(mk(1'b0, 0));
        pending_reqs.push_back(mk(1'b0, 150));
        pending_reqs.push_back(mk(1'b0, 5));
        pending_reqs.push_back(mk(1'b0, 399));
        pending_reqs.push_back(mk(1'b0, 250));
        pending_reqs.push_back(mk(1'b0, 400));
        pending_reqs.push_back(mk(1'b0, 24'hFFFFFF));
        pending_reqs.push_back(mk(1'b1, 24'hFFFFFF));
        pending_reqs.push_back(mk(1'b0, 399));
        drain();
        write_reg(REG_MODE, 1);
        pending_reqs.push_back(mk(1'b0, 0));
        pending_reqs.push_back(mk(1'b0, 120));
        pending_reqs.push_back(mk(1'b0, 1));
        pending_reqs.push_back(mk(1'b0, 250));
        pending_reqs.push_back(mk(1'b0, 130));
        drain();
        // shrink frames to one: a hit on the page in frame 0, then a fault that replaces it
        write_reg(REG_FRAMES, 1);
        pending_reqs.push_back(mk(1'b0, 260));
        pending_reqs.push_back(mk(1'b0, 320));
        drain();
        set_sizes(65536, 256, 16, 0);
        pending_reqs.push_back(mk(1'b0, 24'hFFFFFF));
        pending_reqs.push_back(mk(1'b0, 24'hAAAAAA));
        pending_reqs.push_back(mk(1'b0, 24'h555555));
        drain();

        for (int p = 0; p < 8; p++)
        begin
            phase = (p < 4) ? p : p - 4;
            if (p == 5)
                phase = 4;
            case (p % 4)
                0: set_sizes($urandom_range(1, 300), $urandom_range(1, 40), $urandom_range(1, 16),
                             $urandom_range(0, 1));
                1: set_sizes(1, 256, 16, 1);
                2: set_sizes($urandom_range(1, 65536), 256, $urandom_range(1, 4), 0);
                default: set_sizes($urandom_range(1, 64), $urandom_range(1, 20), 3, 1);
            endcase
            if (p == 7)
                write_reg(REG_VPAGES, 300);
            if (p == 6)
                write_reg(REG_FRAMES, 20);
            push_random(100);
            drain();
        end
        write_reg(REG_ENABLE, 0);
        pending_reqs.push_back(mk(1'b0, 1));
        drain();

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("tb_page_translate_fifo_lru passed");
        else
            $display("tb_page_translate_fifo_lru failed");
        $finish;
    end
endmodule
`default_nettype wire
